// File: src/cpa_pkg.sv
package cpa_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 8;
  localparam int unsigned IO_COORD_W      = 16;
  localparam int unsigned AREA_W          = 32;
  localparam int unsigned AREA_FRAC       = 16;

  // fan triangle sides: (first, prev), (prev, cur), (cur, first)
  localparam logic [1:0] SIDE_FP = 2'd0;
  localparam logic [1:0] SIDE_PC = 2'd1;
  localparam logic [1:0] SIDE_CF = 2'd2;

  typedef enum logic [1:0] {
    SQ_NONE,
    SQ_X,
    SQ_Y
  } sq_op_e;

  typedef enum logic [2:0] {
    U_HOLD,
    U_LD_SIDE,
    U_LD_RAD,
    U_LD_M1,
    U_LD_M2,
    U_LD_M3,
    U_MUL,
    U_SQRT
  } unit_op_e;

  typedef struct packed {
    logic       load_vtx;
    sq_op_e     sq_op;
    logic [1:0] side_sel;
    logic       side_store;
    unit_op_e   unit_op;
    logic       fac_store;
    logic       p1_store;
    logic       tri_acc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic need_tri;
    logic last;
    logic neg;
    logic out_busy;
  } sts_t;

endpackage

// File: src/convex_polygon_area_heron_fan_unit.sv
// Convex polygon area, fan triangulation with Heron's formula per triangle.
// Input channel: one vertex per transaction (x_coord_i, y_coord_i, signed
// fixed point, last_point_i marks the closing vertex). Output channel: one
// transaction per polygon, area_o in unsigned Q16.16 (saturating), with
// too_few_points_o for polygons of one or two vertices and saturated_o when
// a triangle or the running sum clipped.
// The first two vertices are stored without computation. Every later vertex runs three
// side roots, three chained products and the area root on one shared
// shift-add / restoring-root unit, one bit per cycle; the products and
// the area root are skipped when a factor goes negative.
// The result register is loaded once the last vertex finishes and the
// output register is free. in_stall_o is high while a vertex is processed
// or a result waits. A finished result sits in the output register until
// taken; the next polygon may start meanwhile, and its result then waits.
// After reset all polygon state is zero and no result is pending.
module convex_polygon_area_heron_fan_unit #(
  parameter int unsigned COORD_WIDTH = cpa_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = cpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [cpa_pkg::IO_COORD_W-1:0] x_coord_i,
  input  logic signed [cpa_pkg::IO_COORD_W-1:0] y_coord_i,
  input  logic                                  last_point_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [cpa_pkg::AREA_W-1:0]            area_o,
  output logic                                  too_few_points_o,
  output logic                                  saturated_o
);

  cpa_pkg::cmd_t cmd;
  cpa_pkg::sts_t sts;

  cpa_ctrl #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cpa_dpath #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .x_coord_i       (x_coord_i),
    .y_coord_i       (y_coord_i),
    .last_point_i    (last_point_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .area_o          (area_o),
    .too_few_points_o(too_few_points_o),
    .saturated_o     (saturated_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// File: src/cpa_ctrl.sv
module cpa_ctrl #(
  parameter int unsigned COORD_WIDTH = cpa_pkg::COORD_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cpa_pkg::sts_t sts_i,
  output cpa_pkg::cmd_t cmd_o
);

  localparam int unsigned SW    = COORD_WIDTH + 2;
  localparam int unsigned HW    = SW + 2;
  localparam int unsigned PW    = 2 * HW;
  localparam int unsigned RTW   = 2 * HW;
  localparam int unsigned CNT_W = $clog2(RTW + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECIDE = 5'd1;
  localparam logic [4:0] S_SQX    = 5'd2;
  localparam logic [4:0] S_SQY    = 5'd3;
  localparam logic [4:0] S_SLD    = 5'd4;
  localparam logic [4:0] S_SRUN   = 5'd5;
  localparam logic [4:0] S_SST    = 5'd6;
  localparam logic [4:0] S_FAC    = 5'd7;
  localparam logic [4:0] S_CHK    = 5'd8;
  localparam logic [4:0] S_M1LD   = 5'd9;
  localparam logic [4:0] S_M1RUN  = 5'd10;
  localparam logic [4:0] S_M1ST   = 5'd11;
  localparam logic [4:0] S_M2LD   = 5'd12;
  localparam logic [4:0] S_M2RUN  = 5'd13;
  localparam logic [4:0] S_M3LD   = 5'd14;
  localparam logic [4:0] S_M3RUN  = 5'd15;
  localparam logic [4:0] S_RLD    = 5'd16;
  localparam logic [4:0] S_RRUN   = 5'd17;
  localparam logic [4:0] S_ACC    = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  logic [4:0]       state_q, state_d;
  logic [CNT_W-1:0] iter_q, iter_d;
  logic [1:0]       side_q, side_d;
  logic             last_iter;

  assign last_iter  = (iter_q == CNT_W'(1));
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d        = state_q;
    iter_d         = iter_q;
    side_d         = side_q;
    cmd_o          = '0;
    cmd_o.sq_op    = cpa_pkg::SQ_NONE;
    cmd_o.unit_op  = cpa_pkg::U_HOLD;
    cmd_o.side_sel = side_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_vtx = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        side_d = cpa_pkg::SIDE_FP;
        if (sts_i.need_tri) begin
          state_d = S_SQX;
        end else if (sts_i.last) begin
          state_d = S_OUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SQX: begin
        cmd_o.sq_op = cpa_pkg::SQ_X;
        state_d     = S_SQY;
      end
      S_SQY: begin
        cmd_o.sq_op = cpa_pkg::SQ_Y;
        state_d     = S_SLD;
      end
      S_SLD: begin
        cmd_o.unit_op = cpa_pkg::U_LD_SIDE;
        iter_d        = CNT_W'(SW);
        state_d       = S_SRUN;
      end
      S_SRUN: begin
        cmd_o.unit_op = cpa_pkg::U_SQRT;
        iter_d        = iter_q - CNT_W'(1);
        if (last_iter) begin
          state_d = S_SST;
        end
      end
      S_SST: begin
        cmd_o.side_store = 1'b1;
        side_d           = side_q + 2'd1;
        state_d          = (side_q == cpa_pkg::SIDE_CF) ? S_FAC : S_SQX;
      end
      S_FAC: begin
        cmd_o.fac_store = 1'b1;
        state_d         = S_CHK;
      end
      S_CHK: begin
        state_d = sts_i.neg ? S_ACC : S_M1LD;
      end
      S_M1LD: begin
        cmd_o.unit_op = cpa_pkg::U_LD_M1;
        iter_d        = CNT_W'(HW);
        state_d       = S_M1RUN;
      end
      S_M1RUN: begin
        cmd_o.unit_op = cpa_pkg::U_MUL;
        iter_d        = iter_q - CNT_W'(1);
        if (last_iter) begin
          state_d = S_M1ST;
        end
      end
      S_M1ST: begin
        cmd_o.p1_store = 1'b1;
        state_d        = S_M2LD;
      end
      S_M2LD: begin
        cmd_o.unit_op = cpa_pkg::U_LD_M2;
        iter_d        = CNT_W'(HW);
        state_d       = S_M2RUN;
      end
      S_M2RUN: begin
        cmd_o.unit_op = cpa_pkg::U_MUL;
        iter_d        = iter_q - CNT_W'(1);
        if (last_iter) begin
          state_d = S_M3LD;
        end
      end
      S_M3LD: begin
        cmd_o.unit_op = cpa_pkg::U_LD_M3;
        iter_d        = CNT_W'(PW);
        state_d       = S_M3RUN;
      end
      S_M3RUN: begin
        cmd_o.unit_op = cpa_pkg::U_MUL;
        iter_d        = iter_q - CNT_W'(1);
        if (last_iter) begin
          state_d = S_RLD;
        end
      end
      S_RLD: begin
        cmd_o.unit_op = cpa_pkg::U_LD_RAD;
        iter_d        = CNT_W'(RTW);
        state_d       = S_RRUN;
      end
      S_RRUN: begin
        cmd_o.unit_op = cpa_pkg::U_SQRT;
        iter_d        = iter_q - CNT_W'(1);
        if (last_iter) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.tri_acc = 1'b1;
        state_d       = sts_i.last ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
      side_q  <= cpa_pkg::SIDE_FP;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      side_q  <= side_d;
    end
  end

endmodule

// File: src/cpa_dpath.sv
module cpa_dpath #(
  parameter int unsigned COORD_WIDTH = cpa_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = cpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [cpa_pkg::IO_COORD_W-1:0] x_coord_i,
  input  logic signed [cpa_pkg::IO_COORD_W-1:0] y_coord_i,
  input  logic                                  last_point_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic [cpa_pkg::AREA_W-1:0]            area_o,
  output logic                                  too_few_points_o,
  output logic                                  saturated_o,
  input  cpa_pkg::cmd_t                         cmd_i,
  output cpa_pkg::sts_t                         sts_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned SQW = 2 * W + 3;
  localparam int unsigned SW  = W + 2;
  localparam int unsigned HW  = SW + 2;
  localparam int unsigned PW  = 2 * HW;
  localparam int unsigned RW  = 4 * HW;
  localparam int unsigned RTW = 2 * HW;
  localparam int unsigned TW  = RTW + 14;
  localparam int unsigned LSH = (2 * FRAC_BITS <= 14) ? 14 - 2 * FRAC_BITS : 0;
  localparam int unsigned RSH = (2 * FRAC_BITS > 14) ? 2 * FRAC_BITS - 14 : 0;
  localparam int unsigned AW  = cpa_pkg::AREA_W;

  logic signed [W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic [1:0]          cnt_q;
  logic                last_q, need_tri_q, neg_q, ovf_q;
  logic [AW-1:0]       sum_q;
  logic [SQW-1:0]      sq_q;
  logic [SW-1:0]       a_q, b_q, c_q;
  logic [HW-1:0]       s_q, f1_q, f2_q, f3_q;
  logic [PW-1:0]       p1_q, mr_q;
  logic [RW-1:0]       op_q, acc_q;
  logic [RTW-1:0]      rt_q;
  logic [RTW+1:0]      rem_q;
  logic                out_valid_q;

  // side selection and squared distance
  logic signed [W-1:0]   xa, ya, xb, yb;
  logic signed [W:0]     dx, dy, dm;
  logic signed [2*W+1:0] dsq;

  always_comb begin
    case (cmd_i.side_sel)
      cpa_pkg::SIDE_FP: begin
        xa = first_x_q; ya = first_y_q; xb = prev_x_q; yb = prev_y_q;
      end
      cpa_pkg::SIDE_PC: begin
        xa = prev_x_q; ya = prev_y_q; xb = cur_x_q; yb = cur_y_q;
      end
      default: begin
        xa = cur_x_q; ya = cur_y_q; xb = first_x_q; yb = first_y_q;
      end
    endcase
  end

  assign dx  = (W + 1)'(xb) - (W + 1)'(xa);
  assign dy  = (W + 1)'(yb) - (W + 1)'(ya);
  assign dm  = (cmd_i.sq_op == cpa_pkg::SQ_Y) ? dy : dx;
  assign dsq = dm * dm;

  // Heron factors
  logic [HW:0] s_w, f1_w, f2_w, f3_w;
  assign s_w  = (HW + 1)'(a_q) + (HW + 1)'(b_q) + (HW + 1)'(c_q);
  assign f1_w = (HW + 1)'(b_q) + (HW + 1)'(c_q) - (HW + 1)'(a_q);
  assign f2_w = (HW + 1)'(a_q) + (HW + 1)'(c_q) - (HW + 1)'(b_q);
  assign f3_w = (HW + 1)'(a_q) + (HW + 1)'(b_q) - (HW + 1)'(c_q);

  // shared shift-add multiplier / restoring square root
  logic [RTW+1:0] rem_sh, trial;
  assign rem_sh = {rem_q[RTW-1:0], op_q[RW-1 -: 2]};
  assign trial  = {rt_q, 2'b01};

  // triangle area to Q16.16 and sum
  logic [TW-1:0] tri_w;
  logic [AW-1:0] tri32;
  logic          tri_ovf;
  logic [AW:0]   sum_w;
  assign tri_w   = (TW'(rt_q) << LSH) >> RSH;
  assign tri_ovf = !neg_q && (|tri_w[TW-1:AW]);
  assign tri32   = neg_q ? '0 : (tri_ovf ? '1 : tri_w[AW-1:0]);
  assign sum_w   = {1'b0, sum_q} + {1'b0, tri32};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vtx) begin
      cur_x_q <= W'(x_coord_i);
      cur_y_q <= W'(y_coord_i);
    end
    if (cmd_i.sq_op == cpa_pkg::SQ_X) begin
      sq_q <= SQW'(dsq);
    end else if (cmd_i.sq_op == cpa_pkg::SQ_Y) begin
      sq_q <= sq_q + SQW'(dsq);
    end
    if (cmd_i.side_store) begin
      case (cmd_i.side_sel)
        cpa_pkg::SIDE_FP: a_q <= rt_q[SW-1:0];
        cpa_pkg::SIDE_PC: b_q <= rt_q[SW-1:0];
        default:          c_q <= rt_q[SW-1:0];
      endcase
    end
    if (cmd_i.fac_store) begin
      s_q   <= s_w[HW-1:0];
      f1_q  <= f1_w[HW-1:0];
      f2_q  <= f2_w[HW-1:0];
      f3_q  <= f3_w[HW-1:0];
      neg_q <= f1_w[HW] | f2_w[HW] | f3_w[HW];
    end
    if (cmd_i.p1_store) begin
      p1_q <= acc_q[PW-1:0];
    end
    unique case (cmd_i.unit_op)
      cpa_pkg::U_LD_SIDE: begin
        op_q  <= RW'(sq_q) << (RW - 2 * SW);
        rt_q  <= '0;
        rem_q <= '0;
      end
      cpa_pkg::U_LD_RAD: begin
        op_q  <= acc_q;
        rt_q  <= '0;
        rem_q <= '0;
      end
      cpa_pkg::U_LD_M1: begin
        op_q  <= RW'(s_q);
        mr_q  <= PW'(f1_q);
        acc_q <= '0;
      end
      cpa_pkg::U_LD_M2: begin
        op_q  <= RW'(f2_q);
        mr_q  <= PW'(f3_q);
        acc_q <= '0;
      end
      cpa_pkg::U_LD_M3: begin
        op_q  <= RW'(p1_q);
        mr_q  <= acc_q[PW-1:0];
        acc_q <= '0;
      end
      cpa_pkg::U_MUL: begin
        if (mr_q[0]) begin
          acc_q <= acc_q + op_q;
        end
        op_q <= op_q << 1;
        mr_q <= mr_q >> 1;
      end
      cpa_pkg::U_SQRT: begin
        op_q <= op_q << 2;
        if (rem_sh >= trial) begin
          rem_q <= rem_sh - trial;
          rt_q  <= {rt_q[RTW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          rt_q  <= {rt_q[RTW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      area_o           <= (cnt_q == 2'd3) ? sum_q : '0;
      too_few_points_o <= (cnt_q != 2'd3);
      saturated_o      <= (cnt_q == 2'd3) & ovf_q;
    end
  end

  // polygon state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      need_tri_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !cmd_i.out_load) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_vtx) begin
        last_q     <= last_point_i;
        need_tri_q <= cnt_q[1];
        if (cnt_q == 2'd0) begin
          first_x_q <= W'(x_coord_i);
          first_y_q <= W'(y_coord_i);
          cnt_q     <= 2'd1;
        end else if (cnt_q == 2'd1) begin
          prev_x_q <= W'(x_coord_i);
          prev_y_q <= W'(y_coord_i);
          cnt_q    <= 2'd2;
        end
      end
      if (cmd_i.tri_acc) begin
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
        cnt_q    <= 2'd3;
        sum_q    <= sum_w[AW] ? '1 : sum_w[AW-1:0];
        if (tri_ovf || sum_w[AW]) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        first_x_q   <= '0;
        first_y_q   <= '0;
        prev_x_q    <= '0;
        prev_y_q    <= '0;
        cnt_q       <= '0;
        sum_q       <= '0;
        ovf_q       <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.need_tri  = need_tri_q;
  assign sts_o.last      = last_q;
  assign sts_o.neg       = neg_q;
  assign sts_o.out_busy  = out_valid_q & out_stall_i;

endmodule

// File: test/convex_polygon_area_heron_fan_unit_tb.sv
module convex_polygon_area_heron_fan_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRI_SHIFT  = 2 * cpa_pkg::FRAC_BITS_DEF + 2 - cpa_pkg::AREA_FRAC;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 3000;
  localparam int CW         = cpa_pkg::IO_COORD_W;
  localparam int AWID       = cpa_pkg::AREA_W;

  typedef struct {
    logic [AWID-1:0] area;
    logic            few;
    logic            sat;
  } poly_result_t;

  class area_scoreboard;
    longint             first_x, first_y, prev_x, prev_y;
    int                 vtx_count;
    logic [AWID-1:0]    area_sum;
    bit                 clipped;
    poly_result_t       area_q[$];
    int                 errors;

    function new();
      clear_polygon();
      errors = 0;
    endfunction

    function void clear_polygon();
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      vtx_count = 0; area_sum = '0; clipped = 0;
    endfunction

    function logic [127:0] int_sqrt(logic [127:0] v);
      logic [127:0] r, c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function longint side(longint x1, longint y1, longint x2, longint y2);
      longint dx, dy;
      dx = x2 - x1;
      dy = y2 - y1;
      return longint'(int_sqrt(128'(dx * dx + dy * dy)));
    endfunction

    // Heron area in Q16.16, wider than 32 bits so the caller can clip
    function logic [127:0] fan_tri(longint x, longint y);
      longint a, b, c, s, f1, f2, f3;
      logic [127:0] rad, root;
      a = side(first_x, first_y, prev_x, prev_y);
      b = side(prev_x, prev_y, x, y);
      c = side(x, y, first_x, first_y);
      s = a + b + c;
      f1 = b + c - a; f2 = a + c - b; f3 = a + b - c;
      if (f1 < 0 || f2 < 0 || f3 < 0) return '0;
      rad = 128'(s * f1) * 128'(f2 * f3);
      root = int_sqrt(rad);
      if (TRI_SHIFT >= 0) return root >> TRI_SHIFT;
      return root << (-TRI_SHIFT);
    endfunction

    function void note_vertex(logic signed [CW-1:0] x,
                              logic signed [CW-1:0] y, logic last);
      longint       xs, ys;
      logic [127:0] t, sum;
      poly_result_t r;
      xs = longint'(x);
      ys = longint'(y);
      if (vtx_count == 0) begin
        first_x = xs; first_y = ys; vtx_count = 1;
      end else if (vtx_count == 1) begin
        prev_x = xs; prev_y = ys; vtx_count = 2;
      end else begin
        t = fan_tri(xs, ys);
        if (t > 128'hFFFF_FFFF) begin
          t = 128'hFFFF_FFFF;
          clipped = 1;
        end
        sum = t + 128'(area_sum);
        if (sum > 128'hFFFF_FFFF) begin
          sum = 128'hFFFF_FFFF;
          clipped = 1;
        end
        area_sum = sum[AWID-1:0];
        prev_x = xs; prev_y = ys; vtx_count = 3;
      end
      if (last) begin
        if (vtx_count < 3) begin
          r.area = '0; r.few = 1'b1; r.sat = 1'b0;
        end else begin
          r.area = area_sum; r.few = 1'b0; r.sat = clipped;
        end
        area_q.push_back(r);
        clear_polygon();
      end
    endfunction

    function void check_area(logic [AWID-1:0] area, logic few, logic sat);
      poly_result_t e;
      if (area_q.size() == 0) begin
        $display("%0t: unexpected result area=%h few=%b sat=%b", $realtime, area, few, sat);
        errors++;
        return;
      end
      e = area_q.pop_front();
      if (area !== e.area) begin
        $display("%0t: area expected %h actual %h", $realtime, e.area, area);
        errors++;
      end
      if (few !== e.few) begin
        $display("%0t: too_few_points expected %b actual %b", $realtime, e.few, few);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated expected %b actual %b", $realtime, e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [CW-1:0] x_coord_i = '0;
  logic signed [CW-1:0] y_coord_i = '0;
  logic                 last_point_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b1;
  logic [AWID-1:0]      area_o;
  logic                 too_few_points_o;
  logic                 saturated_o;

  area_scoreboard sb = new();
  bit             no_gaps;
  int             idle_cycles;
  int             results_seen;

  convex_polygon_area_heron_fan_unit i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .x_coord_i,
    .y_coord_i,
    .last_point_i,
    .out_valid_o,
    .out_stall_i,
    .area_o,
    .too_few_points_o,
    .saturated_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic send_vertex(logic signed [CW-1:0] x,
                             logic signed [CW-1:0] y, logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    x_coord_i    <= x;
    y_coord_i    <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_vertex(x, y, last);
  endtask

  task automatic send_polygon(int n, int span);
    logic signed [CW-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (span >= 32768) begin
        x = CW'($urandom);
        y = CW'($urandom);
      end else begin
        x = CW'(int'($urandom_range(0, 2 * span)) - span);
        y = CW'(int'($urandom_range(0, 2 * span)) - span);
      end
      send_vertex(x, y, i == n - 1);
    end
  endtask

  // receiving side: random stalls, one long hold-off to back the block up
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = (results_seen == 6) ? HOLD_LEN : (no_gaps ? 0 : $urandom_range(0, 16));
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_area(area_o, too_few_points_o, saturated_o);
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL convex_polygon_area_heron_fan_unit");
      $finish;
    end
  end

  initial begin
    int items;
    int n;
    int span;
    idle_cycles = 0;
    results_seen = 0;
    no_gaps = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one and two vertex polygons
    send_vertex(16'sh0100, 16'sh0200, 1'b1);
    send_vertex(16'sh7FFF, 16'sh8000, 1'b0);
    send_vertex(16'sh8000, 16'sh7FFF, 1'b1);
    // unit right triangle, then a square
    send_vertex(16'sh0000, 16'sh0000, 1'b0);
    send_vertex(16'sh0100, 16'sh0000, 1'b0);
    send_vertex(16'sh0000, 16'sh0100, 1'b1);
    send_vertex(16'sh0000, 16'sh0000, 1'b0);
    send_vertex(16'sh0100, 16'sh0000, 1'b0);
    send_vertex(16'sh0100, 16'sh0100, 1'b0);
    send_vertex(16'sh0000, 16'sh0100, 1'b1);
    // nearly collinear: rounded sides can drive a factor negative
    send_vertex(16'sh0000, 16'sh0000, 1'b0);
    send_vertex(16'sh0003, 16'sh0001, 1'b0);
    send_vertex(16'sh0007, 16'sh0002, 1'b1);
    // corners of the full range, an area near the Q16.16 maximum
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7FFF, 16'sh8000, 1'b0);
    send_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_vertex(16'sh8000, 16'sh7FFF, 1'b0);
    send_vertex(16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh7FFF, 16'sh7FFF, 1'b1);
    // all points equal
    send_vertex(16'shFFFF, 16'shFFFF, 1'b0);
    send_vertex(16'shFFFF, 16'shFFFF, 1'b0);
    send_vertex(16'shFFFF, 16'shFFFF, 1'b1);

    items = 0;
    while (items < 1500) begin
      no_gaps = ($urandom_range(0, 9) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      case ($urandom_range(0, 3))
        0: span = 32768;
        1: span = $urandom_range(1, 64);
        default: span = $urandom_range(1, 32767);
      endcase
      send_polygon(n, span);
      items += n;
    end
    no_gaps = 0;
    in_valid_i <= 1'b0;

    while (sb.area_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS convex_polygon_area_heron_fan_unit");
    end else begin
      $display("FAIL convex_polygon_area_heron_fan_unit");
    end
    $finish;
  end

endmodule
